// ===== src/llr_pkg.sv =====
// ----------------------------------------------------------------------------
// llr_pkg
// Shared widths, register indexes and types of the linear range rescaler.
// ----------------------------------------------------------------------------
package llr_pkg;

  localparam int DataWidth = 32;
  localparam int SpanWidth = DataWidth + 1;
  localparam int ProdWidth = 2 * DataWidth + 1;
  // quotient bits kept; anything from 2^(DataWidth+2) on saturates anyway
  localparam int QuotWidth = DataWidth + 2;
  localparam int AddrWidth = 4;

  localparam logic [AddrWidth-1:0] AddrInLow   = 4'h0;
  localparam logic [AddrWidth-1:0] AddrInHigh  = 4'h4;
  localparam logic [AddrWidth-1:0] AddrOutLow  = 4'h8;
  localparam logic [AddrWidth-1:0] AddrOutHigh = 4'hC;

  localparam logic signed [DataWidth-1:0] InLowReset   = 32'sd0;
  localparam logic signed [DataWidth-1:0] InHighReset  = 32'sd65536;
  localparam logic signed [DataWidth-1:0] OutLowReset  = 32'sd0;
  localparam logic signed [DataWidth-1:0] OutHighReset = 32'sd65536;

  typedef struct packed {
    logic neg;
    logic rerr;
    logic last;
  } side_t;

endpackage

// ===== src/llr_if.sv =====
// ----------------------------------------------------------------------------
// llr_sample_if / llr_result_if
// Valid/ready channels carrying samples in and rescaled results out.
// ----------------------------------------------------------------------------
interface llr_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [llr_pkg::DataWidth-1:0]  sample;
  logic                                  last_sample;

  modport source (output valid, sample, last_sample, input ready);
  modport sink (input valid, sample, last_sample, output ready);
endinterface

interface llr_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [llr_pkg::DataWidth-1:0]  scaled_value;
  logic                                  clipped;
  logic                                  range_error;
  logic                                  last_result;

  modport source (output valid, scaled_value, clipped, range_error, last_result, input ready);
  modport sink (input valid, scaled_value, clipped, range_error, last_result, output ready);
endinterface

// ===== src/llr_div.sv =====
// ----------------------------------------------------------------------------
// llr_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module llr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [llr_pkg::ProdWidth-1:0]   prod,
  input  logic [llr_pkg::SpanWidth-1:0]   divisor,
  input  llr_pkg::side_t                  side_in,
  output logic                            out_valid,
  output logic [llr_pkg::QuotWidth-1:0]   quot,
  output logic                            ovf,
  output llr_pkg::side_t                  side_out
);

  localparam int QW = llr_pkg::QuotWidth;
  localparam int SW = llr_pkg::SpanWidth;
  localparam int PW = llr_pkg::ProdWidth;
  localparam int HW = PW - QW;

  logic [QW:0]         vld;
  logic [SW-1:0]       rem  [QW+1];
  logic [QW-1:0]       lo   [QW+1];
  logic [QW-1:0]       quo  [QW+1];
  logic                ovfs [QW+1];
  llr_pkg::side_t      side [QW+1];

  // entry stage: top bits form the first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= {{(SW-HW){1'b0}}, prod[PW-1:QW]};
      lo[0]   <= prod[QW-1:0];
      quo[0]  <= '0;
      ovfs[0] <= ({{(SW-HW){1'b0}}, prod[PW-1:QW]} >= divisor);
      side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [SW:0]   trial;
    logic          ge;
    logic [SW-1:0] rem_next;

    always_comb begin
      trial    = {rem[k], lo[k][QW-1]};
      ge       = (trial >= {1'b0, divisor});
      rem_next = ge ? SW'(trial - {1'b0, divisor}) : trial[SW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= rem_next;
        lo[k+1]   <= {lo[k][QW-2:0], 1'b0};
        quo[k+1]  <= {quo[k][QW-2:0], ge};
        ovfs[k+1] <= ovfs[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign quot      = quo[QW];
  assign ovf       = ovfs[QW];
  assign side_out  = side[QW];

endmodule

// ===== src/linear_range_rescaler_core.sv =====
// ----------------------------------------------------------------------------
// linear_range_rescaler_core
// Maps Q16.16 samples from [in_low, in_high] onto [out_low, out_high],
// truncating the quotient toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  samples   in   valid/ready      sample, last_sample
//  results   out  valid/ready      scaled_value, clipped, range_error, last_result
//  apb       in   psel/penable     registers in_low, in_high, out_low, out_high
//
//  one sample per clock while the output is not stalled; 38 register stages:
//  magnitudes, multiply, divider entry, 34 divider stages (one quotient bit
//  each) and the output register. the divider chain sets the depth.
//  rst clears the valid bits and loads the register reset values.
//  a stall at the output freezes every stage together; nothing is dropped.
module linear_range_rescaler_core (
  input  logic                              clk,
  input  logic                              rst,
  llr_sample_if.sink                        samples,
  llr_result_if.source                      results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [llr_pkg::AddrWidth-1:0]     paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int DW = llr_pkg::DataWidth;
  localparam int SW = llr_pkg::SpanWidth;
  localparam int PW = llr_pkg::ProdWidth;
  localparam int QW = llr_pkg::QuotWidth;
  localparam int RW = QW + 2;

  logic signed [DW-1:0] in_low;
  logic signed [DW-1:0] in_high;
  logic signed [DW-1:0] out_low;
  logic signed [DW-1:0] out_high;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_low   <= llr_pkg::InLowReset;
      in_high  <= llr_pkg::InHighReset;
      out_low  <= llr_pkg::OutLowReset;
      out_high <= llr_pkg::OutHighReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        llr_pkg::AddrInLow:   in_low   <= pwdata;
        llr_pkg::AddrInHigh:  in_high  <= pwdata;
        llr_pkg::AddrOutLow:  out_low  <= pwdata;
        llr_pkg::AddrOutHigh: out_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      llr_pkg::AddrInLow:   prdata = in_low;
      llr_pkg::AddrInHigh:  prdata = in_high;
      llr_pkg::AddrOutLow:  prdata = out_low;
      llr_pkg::AddrOutHigh: prdata = out_high;
      default:              prdata = '0;
    endcase
  end

  // the user must keep the spans steady while items are in flight; the block does not enforce this
  logic signed [SW-1:0] span_in;
  logic signed [SW-1:0] span_out;
  logic signed [SW-1:0] num;
  logic [SW-1:0]        div_mag;

  assign span_in  = SW'(in_high) - SW'(in_low);
  assign span_out = SW'(out_high) - SW'(out_low);
  assign num      = SW'(samples.sample) - SW'(in_low);
  assign div_mag  = span_in[SW-1] ? SW'(-span_in) : span_in;

  logic en;
  assign en            = !results.valid || results.ready;
  assign samples.ready = en;

  // stage 1: magnitudes and sign
  logic           v1;
  logic [SW-1:0]  a1;
  logic [SW-1:0]  b1;
  llr_pkg::side_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1      <= num[SW-1] ? SW'(-num) : num;
      b1      <= span_out[SW-1] ? SW'(-span_out) : span_out;
      s1.neg  <= num[SW-1] ^ span_out[SW-1] ^ span_in[SW-1];
      s1.rerr <= (span_in == '0);
      s1.last <= samples.last_sample;
    end
  end

  // stage 2: exact product
  logic           v2;
  logic [PW-1:0]  p2;
  llr_pkg::side_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2 <= PW'({{SW{1'b0}}, a1} * {{SW{1'b0}}, b1});
      s2 <= s1;
    end
  end

  logic           dv;
  logic [QW-1:0]  dq;
  logic           dovf;
  llr_pkg::side_t ds;

  llr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .prod      (p2),
    .divisor   (div_mag),
    .side_in   (s2),
    .out_valid (dv),
    .quot      (dq),
    .ovf       (dovf),
    .side_out  (ds)
  );

  // sign, offset and saturation
  logic signed [RW-1:0] sq;
  logic signed [RW-1:0] sum;
  logic signed [DW-1:0] res;
  logic                 clip;

  always_comb begin
    sq   = ds.neg ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
    sum  = sq + RW'(out_low);
    res  = sum[DW-1:0];
    clip = 1'b0;
    priority if (ds.rerr) begin
      res = out_low;
    end else if (dovf) begin
      clip = 1'b1;
      res  = ds.neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else if (sum > $signed(RW'({1'b0, {(DW-1){1'b1}}}))) begin
      clip = 1'b1;
      res  = {1'b0, {(DW-1){1'b1}}};
    end else if (sum < -$signed(RW'({1'b1, {(DW-1){1'b0}}}))) begin
      clip = 1'b1;
      res  = {1'b1, {(DW-1){1'b0}}};
    end else begin
      res = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (en) begin
      results.valid <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.scaled_value <= res;
      results.clipped      <= clip;
      results.range_error  <= ds.rerr;
      results.last_result  <= ds.last;
    end
  end

endmodule
